/* rtl/nmea_sentence_checker_defines.svh */
// ----------------------------------------------------------------------------
// nmea_sentence_checker_defines.svh
// Assertion macros shared by the sentence checker modules.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nsc_pkg.sv */
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, character constants and helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Characters of interest
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    // Offsets that map a hex letter onto its value 10..15
    localparam logic [7:0] UPPER_OFS = 8'h37;
    localparam logic [7:0] LOWER_OFS = 8'h57;

    localparam logic [7:0] MIN_BODY  = 8'd6;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_BODY   = 3'd1,
        PH_HEX1   = 3'd2,
        PH_HEX2   = 3'd3,
        PH_TAIL0  = 3'd4,
        PH_TAILCR = 3'd5,
        PH_TAILLF = 3'd6,
        PH_STOP   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NODOLLAR = 3'd1,
        ERR_SHORT    = 3'd2,
        ERR_BADHEX   = 3'd3,
        ERR_ZEROSUM  = 3'd4,
        ERR_MISMATCH = 3'd5,
        ERR_NOSUM    = 3'd6,
        ERR_BADTAIL  = 3'd7
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       sentence_ok;
        logic [2:0] error_code;
        logic [7:0] computed_sum;
        logic [7:0] body_length;
    } out_item_t;

    // Registered input item handed to the checker core
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

    // Verdict handed from the core to the output register
    typedef struct packed {
        logic      push;
        out_item_t item;
    } verdict_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    // Decode one hex digit, either case; ok is low for anything else
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       h;
        logic [7:0] up;
        logic [7:0] lo;
        up = c - UPPER_OFS;
        lo = c - LOWER_OFS;
        h.ok     = 1'b1;
        h.nibble = c[3:0];
        if (c >= CH_0 && c <= CH_9) begin
            h.nibble = c[3:0];
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.nibble = up[3:0];
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            h.nibble = lo[3:0];
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* rtl/nmea_sentence_checker.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// NMEA 0183 sentence checksum and framing checker, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one sentence byte per transaction, with
//   last_byte set on the final byte. Exactly one verdict transaction leaves on
//   out_valid/out_stall/out_data for each byte with last_byte set; other bytes
//   produce nothing.
//   cfg_valid/cfg_ready/cfg_data write strict_mode; cfg_ready is always high.
//   Write it only while no sentence is in flight.
//   Throughput: one byte per cycle unless a verdict waits on a stalled receiver,
//   set by the combinational parse update in nsc_core between the input and
//   result registers; a verdict enters the result register when it has room.
//   Reset: parse state clears to await a '$', strict_mode clears to 0, and
//   both channel registers empty.
//   Receiver stall: a held verdict stays on out_data; the next last byte then
//   waits in the input register and in_stall rises, while bytes that make no
//   verdict keep flowing as long as the input register can advance.
// ----------------------------------------------------------------------------
module nmea_sentence_checker
    import nsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic     strict_reg;
    stage_t   stg;
    logic     take;
    logic     space;
    verdict_t verdict;

    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            strict_reg <= cfg_data;
        end
    end

    nsc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .take     (take),
        .stg      (stg)
    );

    nsc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .strict_mode (strict_reg),
        .stg         (stg),
        .space       (space),
        .take        (take),
        .verdict     (verdict)
    );

    nsc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .verdict   (verdict),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/nsc_in_reg.sv */
// ----------------------------------------------------------------------------
// nsc_in_reg
// Input register: captures one byte transaction and holds it for the core.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_defines.svh"

module nsc_in_reg
    import nsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     take,
    output stage_t   stg
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // Stall while a held item cannot move on
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign stg.valid = valid_reg;
    assign stg.item  = item_reg;

    `NSC_ASSERT_NEXT(a_hold_item, valid_reg && !take, valid_reg && $stable(item_reg),
        "held input item lost or changed")
    `NSC_ASSERT_NOW(a_take_needs_item, take, valid_reg, "core took an empty stage")

endmodule

/* rtl/nsc_core.sv */
// ----------------------------------------------------------------------------
// nsc_core
// Per-byte parse state update and verdict forming for one sentence.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_defines.svh"

module nsc_core
    import nsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     strict_mode,
    input  stage_t   stg,
    input  logic     space,
    output logic     take,
    output verdict_t verdict
);

    phase_t     phase_reg, phase_next;
    err_t       err_reg, err_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] exp_reg, exp_next;

    phase_t     tk_phase;
    err_t       tk_err;
    logic [7:0] tk_xor;
    logic [7:0] tk_cnt;
    logic [7:0] tk_exp;
    logic [7:0] full_exp;
    hex_t       hx;
    err_t       fin_err;
    logic [7:0] c;
    logic       last;

    // Judge whatever phase is still open when the sentence ends
    function automatic err_t finish_code(input phase_t ph, input err_t err,
                                         input logic [7:0] cnt, input logic strict);
        err_t r;
        r = err;
        case (ph)
            PH_BODY:
            begin
                if (cnt < MIN_BODY)
                    r = ERR_SHORT;
                else if (strict)
                    r = ERR_NOSUM;
            end
            PH_HEX1, PH_HEX2: r = ERR_BADHEX;
            PH_TAILCR:        r = ERR_BADTAIL;
            default:          r = err;
        endcase
        return r;
    endfunction

    assign c        = stg.item.data_byte;
    assign last     = stg.item.last_byte;
    assign hx       = hex_decode(c);
    assign full_exp = {exp_reg[7:4], hx.nibble};

    // Advance when the item makes no verdict or the output has room
    assign take = stg.valid && (!last || space);

    // Apply one byte to the parse state
    always_comb
    begin
        tk_phase = phase_reg;
        tk_err   = err_reg;
        tk_xor   = xor_reg;
        tk_cnt   = cnt_reg;
        tk_exp   = exp_reg;
        if (phase_reg == PH_STOP)
        begin
            tk_phase = PH_STOP;
        end
        else if (phase_reg == PH_START)
        begin
            if (c != CH_DOLLAR)
            begin
                tk_err   = ERR_NODOLLAR;
                tk_phase = PH_STOP;
            end
            else
            begin
                tk_phase = PH_BODY;
            end
        end
        else if (c == CH_NUL)
        begin
            tk_err   = finish_code(phase_reg, err_reg, cnt_reg, strict_mode);
            tk_phase = PH_STOP;
        end
        else
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    if (c == CH_STAR)
                    begin
                        if (cnt_reg < MIN_BODY)
                        begin
                            tk_err   = ERR_SHORT;
                            tk_phase = PH_STOP;
                        end
                        else
                        begin
                            tk_phase = PH_HEX1;
                        end
                    end
                    else
                    begin
                        tk_xor = xor_reg ^ c;
                        if (cnt_reg != COUNT_MAX)
                            tk_cnt = cnt_reg + 8'd1;
                    end
                end
                PH_HEX1:
                begin
                    if (!hx.ok)
                    begin
                        tk_err   = ERR_BADHEX;
                        tk_phase = PH_STOP;
                    end
                    else
                    begin
                        tk_exp   = {hx.nibble, 4'h0};
                        tk_phase = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    if (!hx.ok)
                    begin
                        tk_err   = ERR_BADHEX;
                        tk_phase = PH_STOP;
                    end
                    else
                    begin
                        tk_exp = full_exp;
                        if (full_exp == 8'h00)
                        begin
                            tk_err   = ERR_ZEROSUM;
                            tk_phase = PH_STOP;
                        end
                        else if (full_exp != xor_reg)
                        begin
                            tk_err   = ERR_MISMATCH;
                            tk_phase = PH_STOP;
                        end
                        else
                        begin
                            tk_phase = PH_TAIL0;
                        end
                    end
                end
                PH_TAIL0:
                begin
                    if (c == CH_LF)
                        tk_phase = PH_TAILLF;
                    else if (c == CH_CR)
                        tk_phase = PH_TAILCR;
                    else
                    begin
                        tk_err   = ERR_BADTAIL;
                        tk_phase = PH_STOP;
                    end
                end
                PH_TAILCR:
                begin
                    if (c == CH_LF)
                        tk_phase = PH_TAILLF;
                    else
                    begin
                        tk_err   = ERR_BADTAIL;
                        tk_phase = PH_STOP;
                    end
                end
                default:
                begin
                    tk_err   = ERR_BADTAIL;
                    tk_phase = PH_STOP;
                end
            endcase
        end
    end

    // Next state: commit the byte, or clear after the last byte
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        xor_next   = xor_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        if (take)
        begin
            if (last)
            begin
                phase_next = PH_START;
                err_next   = ERR_NONE;
                xor_next   = 8'h00;
                cnt_next   = 8'h00;
                exp_next   = 8'h00;
            end
            else
            begin
                phase_next = tk_phase;
                err_next   = tk_err;
                xor_next   = tk_xor;
                cnt_next   = tk_cnt;
                exp_next   = tk_exp;
            end
        end
    end

    // Outputs: form the verdict at the last byte
    always_comb
    begin
        fin_err                   = finish_code(tk_phase, tk_err, tk_cnt, strict_mode);
        verdict.push              = stg.valid && last && space;
        verdict.item.sentence_ok  = (fin_err == ERR_NONE);
        verdict.item.error_code   = fin_err;
        verdict.item.computed_sum = tk_xor;
        verdict.item.body_length  = tk_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            err_reg   <= ERR_NONE;
            xor_reg   <= 8'h00;
            cnt_reg   <= 8'h00;
            exp_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            xor_reg   <= xor_next;
            cnt_reg   <= cnt_next;
            exp_reg   <= exp_next;
        end
    end

    `NSC_ASSERT_NEXT(a_clear_after_verdict, verdict.push,
        phase_reg == PH_START && err_reg == ERR_NONE && cnt_reg == 8'h00,
        "sentence state not cleared after verdict")
    `NSC_ASSERT_NOW(a_error_means_stop, err_reg != ERR_NONE, phase_reg == PH_STOP,
        "error recorded while parsing continues")
    `NSC_ASSERT_NOW(a_ok_matches_code, verdict.push,
        verdict.item.sentence_ok == (verdict.item.error_code == ERR_NONE),
        "verdict flag disagrees with error code")

endmodule

/* rtl/nsc_out_reg.sv */
// ----------------------------------------------------------------------------
// nsc_out_reg
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_defines.svh"

module nsc_out_reg
    import nsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  verdict_t  verdict,
    output logic      space,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Room when empty or the current transaction leaves this cycle
    assign space = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (verdict.push)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load verdict payload
    always_ff @(posedge clk)
    begin
        if (verdict.push)
        begin
            item_reg <= verdict.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = item_reg;

    `NSC_ASSERT_NOW(a_no_overwrite, verdict.push, !(valid_reg && out_stall),
        "verdict pushed over a stalled result")

endmodule

/* dv/nmea_sentence_checker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_tb
// Self-checking bench for the NMEA sentence checker. Directed sentences cover
// framing, checksum, tail and strict-mode cases. Random sentences follow, most
// of them well formed and some broken. A cycle-level predictor tracks every
// accepted byte and queues the verdict that each last byte must produce.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_tb;
    import nsc_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RUN_LIMIT_CYCLES = 400000;
    localparam int PHASE_BYTES      = 56;
    localparam int LONG_BODY_BYTES  = 260;

    typedef logic [7:0] byte_q_t[$];

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    // Predictor state for the sentence in progress
    logic       strict_q        = 1'b0;
    phase_t     sentence_phase  = PH_START;
    logic [7:0] body_xor        = '0;
    logic [7:0] body_len        = '0;
    logic [7:0] claimed_sum     = '0;
    err_t       first_fault     = ERR_NONE;

    out_item_t verdict_q[$];
    int        errors         = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_requests  = 0;
    int        holds_served   = 0;
    int        hold_left      = 0;

    nmea_sentence_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_sentence();
        sentence_phase = PH_START;
        body_xor       = '0;
        body_len       = '0;
        claimed_sum    = '0;
        first_fault    = ERR_NONE;
    endfunction

    // Record only the first fault, then ignore bytes up to the last one
    function automatic void flag_fault(input err_t code);
        if (first_fault == ERR_NONE)
        begin
            first_fault = code;
        end
        sentence_phase = PH_STOP;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return c - CH_0;
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            return c - CH_UA + 10;
        end
        if (c >= CH_LA && c <= CH_LF_HEX)
        begin
            return c - CH_LA + 10;
        end
        return -1;
    endfunction

    // Judge whatever phase is open when the sentence ends
    function automatic void close_sentence();
        case (sentence_phase)
            PH_BODY:
            begin
                if (body_len < MIN_BODY)
                begin
                    flag_fault(ERR_SHORT);
                end
                else if (strict_q)
                begin
                    flag_fault(ERR_NOSUM);
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                flag_fault(ERR_BADHEX);
            end
            PH_TAILCR:
            begin
                flag_fault(ERR_BADTAIL);
            end
            default:
            begin
            end
        endcase
        sentence_phase = PH_STOP;
    endfunction

    function automatic void absorb_byte(input logic [7:0] c);
        int nib;
        nib = hex_nibble(c);
        if (sentence_phase == PH_STOP)
        begin
            return;
        end
        if (sentence_phase == PH_START)
        begin
            if (c != CH_DOLLAR)
            begin
                flag_fault(ERR_NODOLLAR);
            end
            else
            begin
                sentence_phase = PH_BODY;
            end
            return;
        end
        // A zero byte ends the sentence where it stands
        if (c == CH_NUL)
        begin
            close_sentence();
            return;
        end
        case (sentence_phase)
            PH_BODY:
            begin
                if (c == CH_STAR)
                begin
                    if (body_len < MIN_BODY)
                    begin
                        flag_fault(ERR_SHORT);
                    end
                    else
                    begin
                        sentence_phase = PH_HEX1;
                    end
                end
                else
                begin
                    body_xor ^= c;
                    if (body_len != COUNT_MAX)
                    begin
                        body_len++;
                    end
                end
            end
            PH_HEX1:
            begin
                if (nib < 0)
                begin
                    flag_fault(ERR_BADHEX);
                end
                else
                begin
                    claimed_sum    = {nib[3:0], 4'h0};
                    sentence_phase = PH_HEX2;
                end
            end
            PH_HEX2:
            begin
                if (nib < 0)
                begin
                    flag_fault(ERR_BADHEX);
                end
                else
                begin
                    claimed_sum[3:0] = nib[3:0];
                    if (claimed_sum == 8'h00)
                    begin
                        flag_fault(ERR_ZEROSUM);
                    end
                    else if (claimed_sum != body_xor)
                    begin
                        flag_fault(ERR_MISMATCH);
                    end
                    else
                    begin
                        sentence_phase = PH_TAIL0;
                    end
                end
            end
            PH_TAIL0:
            begin
                if (c == CH_LF)
                begin
                    sentence_phase = PH_TAILLF;
                end
                else if (c == CH_CR)
                begin
                    sentence_phase = PH_TAILCR;
                end
                else
                begin
                    flag_fault(ERR_BADTAIL);
                end
            end
            PH_TAILCR:
            begin
                if (c == CH_LF)
                begin
                    sentence_phase = PH_TAILLF;
                end
                else
                begin
                    flag_fault(ERR_BADTAIL);
                end
            end
            default:
            begin
                flag_fault(ERR_BADTAIL);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check verdicts, then track config and input transactions
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            strict_q = 1'b0;
            clear_sentence();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: verdict with none expected: expected nothing, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.sentence_ok !== want.sentence_ok)
                    begin
                        errors++;
                        $display("%0t: sentence_ok expected %0b actual %0b",
                                 $time, want.sentence_ok, out_data.sentence_ok);
                    end
                    if (out_data.error_code !== want.error_code)
                    begin
                        errors++;
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.error_code, out_data.error_code);
                    end
                    if (out_data.computed_sum !== want.computed_sum)
                    begin
                        errors++;
                        $display("%0t: computed_sum expected %02h actual %02h",
                                 $time, want.computed_sum, out_data.computed_sum);
                    end
                    if (out_data.body_length !== want.body_length)
                    begin
                        errors++;
                        $display("%0t: body_length expected %0d actual %0d",
                                 $time, want.body_length, out_data.body_length);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                strict_q = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                absorb_byte(in_data.data_byte);
                if (in_data.last_byte)
                begin
                    close_sentence();
                    verdict_q.push_back('{sentence_ok:  first_fault == ERR_NONE,
                                          error_code:   first_fault,
                                          computed_sum: body_xor,
                                          body_length:  body_len});
                    clear_sentence();
                end
            end
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left == 0 && holds_served != hold_requests)
        begin
            hold_left = HOLD_OFF_CYCLES;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_sentence(input byte_q_t s);
        foreach (s[i])
        begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    // Stop offering and wait until every verdict has come back
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        do @(posedge clk); while (verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_strict(input logic mode);
        drain_verdicts();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic byte_q_t text_bytes(input string t);
        byte_q_t s;
        for (int i = 0; i < t.len(); i++)
        begin
            s.push_back(t[i]);
        end
        return s;
    endfunction

    // Frame a body with a correct checksum and the given tail
    function automatic string framed(input string body, input string tail, input bit lower);
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < body.len(); i++)
        begin
            sum ^= body[i];
        end
        if (lower)
        begin
            return $sformatf("$%s*%02x%s", body, sum, tail);
        end
        return $sformatf("$%s*%02X%s", body, sum, tail);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
        begin
            return CH_0 + v;
        end
        return (upper ? CH_UA : CH_LA) + v - 8'd10;
    endfunction

    // Mostly well-formed sentences with random content, some broken ones
    function automatic byte_q_t random_sentence();
        byte_q_t    s;
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        int         kind;
        int         hex_pos;
        sum     = '0;
        hex_pos = 0;
        n    = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 24);
        kind = $urandom_range(99);
        s.push_back(CH_DOLLAR);
        repeat (n)
        begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_STAR);
            s.push_back(b);
            sum ^= b;
        end
        // Corrupt the claimed checksum
        if (kind >= 8 && kind < 13)
        begin
            sum ^= 8'($urandom_range(1, 255));
        end
        // Append the checksum field unless the sentence goes without one
        if (kind >= 8)
        begin
            s.push_back(CH_STAR);
            hex_pos = s.size();
            s.push_back(hex_char(sum[7:4], 1'($urandom_range(1))));
            s.push_back(hex_char(sum[3:0], 1'($urandom_range(1))));
        end
        case ($urandom_range(2))
            1:
            begin
                s.push_back(CH_LF);
            end
            2:
            begin
                s.push_back(CH_CR);
                s.push_back(CH_LF);
            end
            default:
            begin
            end
        endcase
        if (kind >= 13 && kind < 17)
        begin
            s[hex_pos + $urandom_range(1)] = 8'($urandom_range(255));
        end
        else if (kind >= 17 && kind < 20)
        begin
            s = s[0 : hex_pos - 1 + $urandom_range(1)];
        end
        else if (kind >= 20 && kind < 23)
        begin
            s.insert(1 + $urandom_range(s.size() - 1), CH_NUL);
        end
        else if (kind >= 23 && kind < 26)
        begin
            s[0] = 8'($urandom_range(255));
        end
        else if (kind >= 26 && kind < 29)
        begin
            repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(255)));
        end
        else if (kind >= 29 && kind < 31)
        begin
            s.push_back(CH_CR);
        end
        else if (kind >= 31 && kind < 34)
        begin
            s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_framing();
        send_sentence(text_bytes("$"));
        send_sentence(text_bytes("GPGGA,1*00"));
        send_sentence(text_bytes("$GPG"));
        // Short body at the asterisk wins over the later bad digits and tail
        send_sentence(text_bytes("$AB*ZZ\r"));
    endtask

    task automatic test_checksum();
        send_sentence(text_bytes(framed("GPGLL,4916.45", "", 1'b0)));
        send_sentence(text_bytes(framed("GPGLL,4916.45", "\r\n", 1'b0)));
        send_sentence(text_bytes(framed("gprmc,a", "\n", 1'b1)));
        send_sentence(text_bytes("$GPGLL,1*00"));
        send_sentence(text_bytes("$GPGLL,1*FF"));
        send_sentence(text_bytes("$GPGLL,1*G0"));
        send_sentence(text_bytes("$GPGLL,1* 5"));
        send_sentence(text_bytes("$GPGLL,1*4"));
        send_sentence(text_bytes("$GPGLL,1*"));
    endtask

    task automatic test_tail();
        send_sentence(text_bytes(framed("GPVTG,1", "\r", 1'b0)));
        send_sentence(text_bytes(framed("GPVTG,1", "\nX", 1'b0)));
        send_sentence(text_bytes(framed("GPVTG,1", "X", 1'b0)));
        send_sentence(text_bytes(framed("GPVTG,1", "\r\r", 1'b0)));
    endtask

    task automatic test_zero_byte();
        byte_q_t s;
        s = text_bytes("$GPGGA,1junk*00");
        s.insert(8, CH_NUL);
        send_sentence(s);
        s = text_bytes("GPGGA,1");
        s.push_front(CH_NUL);
        send_sentence(s);
        s = text_bytes("$GP");
        s.push_back(CH_NUL);
        send_sentence(s);
    endtask

    task automatic test_strict_mode();
        write_strict(1'b1);
        send_sentence(text_bytes("$GPGLL,1"));
        send_sentence(text_bytes("$GPG"));
        send_sentence(text_bytes(framed("GPGLL,1", "\r\n", 1'b0)));
        write_strict(1'b0);
        send_sentence(text_bytes("$GPGLL,1"));
    endtask

    // Body long enough to saturate the length count, with high-bit bytes
    task automatic test_long_body();
        byte_q_t    s;
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        s.push_back(CH_DOLLAR);
        for (int i = 0; i < LONG_BODY_BYTES; i++)
        begin
            b = 8'hFF ^ {1'b0, i[6:0]};
            s.push_back(b);
            sum ^= b;
        end
        s.push_back(CH_STAR);
        s.push_back(hex_char(sum[7:4], 1'b1));
        s.push_back(hex_char(sum[3:0], 1'b1));
        send_sentence(s);
    endtask

    // Hold the receiver off while bytes keep coming, so the input backs up
    task automatic test_hold_off();
        drain_verdicts();
        hold_requests++;
        repeat (8) send_sentence(random_sentence());
        drain_verdicts();
    endtask

    task automatic test_random();
        int sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_strict(phase[0]);
            send_idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 30 : 0;
            recv_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 30 : 0;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                byte_q_t s;
                s = random_sentence();
                sent += s.size();
                send_sentence(s);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_framing();
        test_checksum();
        test_tail();
        test_zero_byte();
        test_strict_mode();
        test_long_body();
        test_hold_off();
        test_random();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_verdicts();
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
